// File: rtl/mag_average_and_offset_calibration_defines.svh
// Assertion macros shared by the RTL of the magnetometer calibration block.
`ifndef MAG_AVERAGE_AND_OFFSET_CALIBRATION_DEFINES_SVH
`define MAG_AVERAGE_AND_OFFSET_CALIBRATION_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define MAG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the following cycle.
`define MAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mag_pkg.sv
package mag_pkg;

    localparam int AVG_DEPTH_DEF = 10;
    localparam int SAMPLE_W = 16;
    localparam int VAL_W = 17;
    localparam int GAIN_W = 32;
    localparam int CAL_W = 16;
    localparam logic [CAL_W-1:0] CAL_CYCLES_RESET = 16'd1000;
    localparam logic [GAIN_W-1:0] GAIN_Y_RESET = 32'd55955;
    localparam logic [GAIN_W-1:0] GAIN_Z_RESET = 32'd61532;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = -16'sd100;
    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sd100;
    localparam logic signed [SAMPLE_W-1:0] OFFSET_RESET = -16'sd1;

    // Request and response of the shared gain divider.
    typedef struct packed {
        logic        start;
        logic [16:0] num;
        logic [16:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;

endpackage

// File: rtl/mag_average_and_offset_calibration.sv
// Three-axis magnetometer moving average with min/max hard-iron calibration.
// Input channel: raw_x/y/z and start_cal, transferred by in_valid/in_ready.
// Output channel: averages, offset-corrected values, offsets, gains and
// cal_done, transferred by out_valid/out_ready; one result per transaction.
// Configuration channel: cfg_valid/cfg_ready carry cal_cycles.
// A sample passes from acceptance to a valid result through a ring memory
// read, a read-modify-write of the ring with the running sums, a reciprocal
// multiplication that divides the sums by the ring depth, the offset
// correction and min/max and offset update, then the load of the output
// register. A sample that completes a calibration adds a second tracking
// pass and two serial Q16.16 gain divisions, run in turn on the one shared
// divider. One sample is processed at a time: a new sample is not accepted
// until the last one has loaded its result. The result sits in an output
// register, and a new sample is accepted as soon as the output register is
// free or being taken, so a stalled receiver stalls the input after one
// buffered result. After reset the ring reads as zero through a clearing
// pass over every entry during which in_ready is low; sums, offsets and
// gains take their reset values at once.
module mag_average_and_offset_calibration #(
    parameter int AVG_DEPTH = mag_pkg::AVG_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic signed [15:0] raw_z,
    input  logic               start_cal,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] avg_x,
    output logic signed [15:0] avg_y,
    output logic signed [15:0] avg_z,
    output logic signed [16:0] val_x,
    output logic signed [16:0] val_y,
    output logic signed [16:0] val_z,
    output logic signed [15:0] offset_x,
    output logic signed [15:0] offset_y,
    output logic signed [15:0] offset_z,
    output logic [31:0]        gain_y_out,
    output logic [31:0]        gain_z_out,
    output logic               cal_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    localparam int AW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    // Sum width: 17 bits plus the ceiling log2 of the depth, signed.
    localparam int SW = 17 + $clog2(AVG_DEPTH);
    // The division by the ring depth multiplies the sum magnitude by a
    // rounded-up reciprocal. Its error times the largest sum magnitude stays
    // below two to the shift, so the quotient is exact after truncation.
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_MUL = ((1 << RECIP_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int PW = SW + RECIP_SHIFT;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_DIVIDE, ST_TRACK,
        ST_GAIN_Y, ST_GAIN_Z, ST_OUT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] slot_reg;
    logic [15:0] cal_cycles_reg;
    logic calibrating_reg;
    logic [15:0] cal_count_reg;
    logic signed [SW-1:0] sum_reg [3];
    logic signed [15:0] raw_reg [3];
    logic signed [15:0] avg_reg [3];
    logic signed [15:0] max_reg [3];
    logic signed [15:0] min_reg [3];
    logic signed [15:0] off_reg [3];
    logic signed [16:0] val_reg [3];
    logic signed [15:0] ooff_reg [3];
    logic [31:0] gain_y_reg;
    logic [31:0] gain_z_reg;
    logic [31:0] ogy_reg;
    logic [31:0] ogz_reg;
    logic done_reg;
    logic finish_reg;
    logic out_valid_reg;

    logic [SW-1:0] sum_mag [3];
    logic [PW-1:0] prod [3];
    logic [15:0] quo_mag [3];
    logic signed [15:0] avg_div [3];
    logic [16:0] rng [3];

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [47:0] ram_wdata;
    logic [47:0] ram_rdata;
    mag_pkg::div_req_t div_req;
    mag_pkg::div_rsp_t div_rsp;
    logic in_fire;
    logic out_free;

    mag_ram #(.WIDTH(48), .DEPTH(AVG_DEPTH)) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    mag_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire = in_valid && in_ready;
    assign cfg_ready = (state_reg == ST_IDLE);

    // Ring writes come from the clearing pass or from the update step.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = {raw_reg[2], raw_reg[1], raw_reg[0]};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            ram_we = 1'b1;
        end
    end

    // Averages truncate toward zero, so the magnitude is divided and the sign
    // restored afterwards. The ranges come straight from the extremes, which
    // already hold the last sample when the divider is started.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum_mag[a] = sum_reg[a][SW-1] ? $unsigned(-sum_reg[a]) : $unsigned(sum_reg[a]);
            prod[a]    = PW'(sum_mag[a]) * PW'(RECIP_MUL);
            quo_mag[a] = prod[a][RECIP_SHIFT +: 16];
            avg_div[a] = sum_reg[a][SW-1] ? $signed(-quo_mag[a]) : $signed(quo_mag[a]);
            rng[a]     = 17'(max_reg[a]) - 17'(min_reg[a]);
        end
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = rng[0];
        div_req.den   = rng[1];
        if (state_reg == ST_TRACK && finish_reg)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == ST_GAIN_Y && div_rsp.done)
        begin
            div_req.start = 1'b1;
            div_req.den   = rng[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            slot_reg        <= '0;
            cal_cycles_reg  <= mag_pkg::CAL_CYCLES_RESET;
            calibrating_reg <= 1'b0;
            cal_count_reg   <= '0;
            gain_y_reg      <= mag_pkg::GAIN_Y_RESET;
            gain_z_reg      <= mag_pkg::GAIN_Z_RESET;
            out_valid_reg   <= 1'b0;
            finish_reg      <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
                max_reg[a] <= mag_pkg::MAX_RESET;
                min_reg[a] <= mag_pkg::MIN_RESET;
                off_reg[a] <= mag_pkg::OFFSET_RESET;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                cal_cycles_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(AVG_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        raw_reg[0] <= raw_x;
                        raw_reg[1] <= raw_y;
                        raw_reg[2] <= raw_z;
                        if (start_cal)
                        begin
                            calibrating_reg <= 1'b1;
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        sum_reg[a] <= sum_reg[a] + SW'(raw_reg[a])
                            - SW'($signed(ram_rdata[16*a +: 16]));
                    end
                    slot_reg <= (slot_reg == AW'(AVG_DEPTH - 1)) ? '0 : slot_reg + AW'(1);
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        avg_reg[a] <= avg_div[a];
                    end
                    state_reg <= ST_TRACK;
                end
                ST_TRACK:
                begin
                    // The offsets read here are still the ones from before
                    // this sample, on both passes of a finishing sample.
                    for (int a = 0; a < 3; a++)
                    begin
                        val_reg[a] <= 17'(avg_reg[a]) - 17'(off_reg[a]);
                    end
                    // On finish, offsets and ranges use the updated extremes.
                    finish_reg <= 1'b0;
                    state_reg  <= ST_OUT;
                    if (calibrating_reg)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            if (avg_reg[a] > max_reg[a])
                            begin
                                max_reg[a] <= avg_reg[a];
                            end
                            if (avg_reg[a] < min_reg[a])
                            begin
                                min_reg[a] <= avg_reg[a];
                            end
                        end
                        if (!finish_reg && cal_count_reg == cal_cycles_reg)
                        begin
                            finish_reg <= 1'b1;
                            state_reg  <= ST_TRACK;
                        end
                        else if (finish_reg)
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                off_reg[a] <= 16'((17'(max_reg[a]) + 17'(min_reg[a])) / 17'sd2);
                            end
                            cal_count_reg   <= 16'd1;
                            calibrating_reg <= 1'b0;
                            state_reg       <= ST_GAIN_Y;
                        end
                        else
                        begin
                            cal_count_reg <= cal_count_reg + 16'd1;
                        end
                    end
                end
                ST_GAIN_Y:
                begin
                    if (div_rsp.done)
                    begin
                        gain_y_reg <= div_rsp.quot;
                        state_reg  <= ST_GAIN_Z;
                    end
                end
                ST_GAIN_Z:
                begin
                    if (div_rsp.done)
                    begin
                        gain_z_reg <= div_rsp.quot;
                        state_reg  <= ST_OUT;
                        finish_reg <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        done_reg      <= finish_reg;
                        finish_reg    <= 1'b0;
                        ogy_reg       <= gain_y_reg;
                        ogz_reg       <= gain_z_reg;
                        for (int a = 0; a < 3; a++)
                        begin
                            ooff_reg[a] <= off_reg[a];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign avg_x      = avg_reg[0];
    assign avg_y      = avg_reg[1];
    assign avg_z      = avg_reg[2];
    assign val_x      = val_reg[0];
    assign val_y      = val_reg[1];
    assign val_z      = val_reg[2];
    assign offset_x   = ooff_reg[0];
    assign offset_y   = ooff_reg[1];
    assign offset_z   = ooff_reg[2];
    assign gain_y_out = ogy_reg;
    assign gain_z_out = ogz_reg;
    assign cal_done   = done_reg;

`include "mag_average_and_offset_calibration_defines.svh"

    `MAG_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !in_ready,
        "input accepted while a sample is in flight")
    `MAG_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, state_reg == ST_READ,
        "accepted sample did not start the ring read")
    `MAG_ASSERT_IMP(a_slot_range, clk, rst_n, 1'b1, slot_reg < AW'(AVG_DEPTH),
        "ring slot beyond depth")
    `MAG_ASSERT_NEXT(a_done_ends_cal, clk, rst_n,
        state_reg == ST_GAIN_Y, !calibrating_reg,
        "calibration still active during gain computation")

endmodule

// File: rtl/mag_ram.sv
module mag_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/mag_div.sv
// Restoring divider: quotient = num * 65536 / den, one quotient bit per cycle.
// A zero divisor or a quotient beyond 32 bits saturates to all ones.
module mag_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mag_pkg::div_req_t req,
    output mag_pkg::div_rsp_t rsp
);

    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] num_reg;
    logic [17:0] rem_reg;
    logic [16:0] den_reg;
    logic [32:0] quot_reg;
    logic        zero_reg;
    logic        done_reg;
    logic [17:0] trial;
    logic [17:0] shifted;

    assign shifted = {rem_reg[16:0], num_reg[32]};
    assign trial = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
                num_reg  <= {req.num, 16'd0};
                den_reg  <= req.den;
                zero_reg <= (req.den == '0);
                rem_reg  <= '0;
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[31:0], 1'b0};
                if (!trial[17])
                begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted;
                    quot_reg <= {quot_reg[31:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (zero_reg || quot_reg[32]) ? '1 : quot_reg[31:0];

endmodule
